// ===== rtl/core/cpb_pkg.sv =====
// shared types, constants and helpers for the particle cell binning core
`timescale 1ns / 1ps

package cpb_pkg;

    // largest cell count along one axis
    localparam logic [10:0] MAX_CELLS_AXIS = 11'd1024;

    // one half in the q.40 product format
    localparam logic [63:0] HALF_Q40 = 64'd1 << 39;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_YZ    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE_YZ = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL_YZ = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_DIST   = 3'd6;

    // input item
    typedef struct packed {
        logic [23:0]        particle_id;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_in;

    // result item
    typedef struct packed {
        logic [23:0] particle_id_out;
        logic [29:0] cell_index;
        logic        is_neighbour;
        logic        range_error;
        logic        last_of_particle;
    } t_out;

    // binning of one axis
    typedef struct packed {
        logic signed [26:0] home;
        logic signed [26:0] near;
        logic               marked;
        logic               home_oor;
        logic               near_oor;
    } t_axis_res;

    // the eight candidate cells of one particle, bit m selects near on axis m
    typedef struct packed {
        logic [7:0][29:0] flat;
        logic [7:0]       err;
        logic [7:0]       use_m;
    } t_cand;

    // a zero count acts as one, a count above the limit as the limit
    function automatic logic [10:0] eff_count(input logic [10:0] n);
        logic [10:0] r;
        if (n == 11'd0) begin
            r = 11'd1;
        end else if (n > MAX_CELLS_AXIS) begin
            r = MAX_CELLS_AXIS;
        end else begin
            r = n;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/cpb_axis.sv =====
// six stage binning pipeline for one axis: home cell, near cell and link test
`timescale 1ns / 1ps

module cpb_axis (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic                  i_clamp,
    input  logic signed [31:0]    i_pos,
    input  logic [31:0]           i_inv,
    input  logic [30:0]           i_size,
    input  logic [30:0]           i_link,
    input  logic [10:0]           i_n,
    output cpb_pkg::t_axis_res    o_res
);

    logic signed [11:0] n_s;
    assign n_s = $signed({1'b0, i_n});

    // stage 1: sign and magnitude
    logic               r1_neg;
    logic [31:0]        r1_mag;
    logic signed [31:0] r1_pos;
    logic [31:0]        n1_mag;
    assign n1_mag = i_pos[31] ? (~i_pos + 32'd1) : i_pos;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_neg <= i_pos[31];
            r1_mag <= n1_mag;
            r1_pos <= i_pos;
        end
    end

    // stage 2: magnitude times reciprocal, exact q.40
    logic               r2_neg;
    logic [63:0]        r2_prod;
    logic signed [31:0] r2_pos;
    logic [63:0]        n2_prod;
    assign n2_prod = r1_mag * i_inv;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_neg  <= r1_neg;
            r2_prod <= n2_prod;
            r2_pos  <= r1_pos;
        end
    end

    // stage 3: truncated index and nearest edge
    logic signed [24:0] r3_trunc;
    logic signed [25:0] r3_edge;
    logic signed [31:0] r3_pos;
    logic signed [24:0] n3_trunc;
    logic signed [25:0] n3_edge;

    always_comb begin
        logic signed [24:0] q_s;
        logic [64:0]        rnd;
        logic [63:0]        sub;
        q_s = $signed({1'b0, r2_prod[63:40]});
        rnd = {1'b0, r2_prod} + {1'b0, cpb_pkg::HALF_Q40};
        sub = r2_prod - cpb_pkg::HALF_Q40;
        n3_trunc = r2_neg ? -q_s : q_s;
        if (!r2_neg) begin
            n3_edge = $signed({1'b0, rnd[64:40]});
        end else if (r2_prod <= cpb_pkg::HALF_Q40) begin
            n3_edge = 26'sd0;
        end else begin
            n3_edge = -$signed({2'b00, sub[63:40]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_trunc <= n3_trunc;
            r3_edge  <= n3_edge;
            r3_pos   <= r2_pos;
        end
    end

    // stage 4: edge position, home index with clamp or wrap, raw near index
    logic signed [57:0] r4_esz;
    logic signed [25:0] r4_ic;
    logic signed [26:0] r4_c;
    logic signed [31:0] r4_pos;
    logic signed [57:0] n4_esz;
    logic signed [25:0] n4_ic;
    logic signed [26:0] n4_c;
    logic signed [31:0] size_s;
    assign size_s = $signed({1'b0, i_size});
    assign n4_esz = r3_edge * size_s;

    always_comb begin
        logic signed [25:0] t26;
        logic signed [25:0] n26;
        logic signed [26:0] d27;
        t26 = 26'(r3_trunc);
        n26 = 26'(n_s);
        if (r3_trunc >= n_s) begin
            n4_ic = i_clamp ? (n26 - 26'sd1) : (t26 - n26);
        end else if (r3_trunc < 25'sd0) begin
            n4_ic = i_clamp ? 26'sd0 : (t26 + n26);
        end else begin
            n4_ic = t26;
        end
        d27  = 27'(r3_edge) - 27'(r3_trunc);
        n4_c = 27'(n4_ic) - 27'sd1 + (d27 <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_esz <= n4_esz;
            r4_ic  <= n4_ic;
            r4_c   <= n4_c;
            r4_pos <= r3_pos;
        end
    end

    // stage 5: signed edge distance, near index wrap or drop
    logic signed [57:0] r5_diff;
    logic signed [25:0] r5_ic;
    logic signed [26:0] r5_cadj;
    logic               r5_drop;
    logic signed [26:0] n5_cadj;
    logic               n5_drop;

    always_comb begin
        logic signed [26:0] n27;
        n27 = 27'(n_s);
        n5_drop = 1'b0;
        if (r4_c >= n27) begin
            n5_drop = i_clamp;
            n5_cadj = r4_c - n27;
        end else if (r4_c < 27'sd0) begin
            n5_drop = i_clamp;
            n5_cadj = r4_c + n27;
        end else begin
            n5_cadj = r4_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_diff <= r4_esz - 58'(r4_pos);
            r5_ic   <= r4_ic;
            r5_cadj <= n5_cadj;
            r5_drop <= n5_drop;
        end
    end

    // stage 6: link test and range flags
    cpb_pkg::t_axis_res r6_res;
    cpb_pkg::t_axis_res n6_res;

    always_comb begin
        logic signed [57:0] link_s;
        logic signed [26:0] n27;
        logic               in_reach;
        link_s   = $signed({27'd0, i_link});
        n27      = 27'(n_s);
        in_reach = (r5_diff <= link_s) && (r5_diff >= -link_s);
        n6_res.marked   = in_reach && !r5_drop;
        n6_res.home     = 27'(r5_ic);
        n6_res.near     = n6_res.marked ? r5_cadj : 27'sd0;
        n6_res.home_oor = (n6_res.home < 27'sd0) || (n6_res.home >= n27);
        n6_res.near_oor = (n6_res.near < 27'sd0) || (n6_res.near >= n27);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_res <= n6_res;
        end
    end

    assign o_res = r6_res;

endmodule

// ===== rtl/core/cpb_flat.sv =====
// two stage flat index builder: axis products, then the eight candidate sums
`timescale 1ns / 1ps

module cpb_flat (
    input  logic               i_clk,
    input  logic               i_en,
    input  cpb_pkg::t_axis_res i_ax_x,
    input  cpb_pkg::t_axis_res i_ax_y,
    input  cpb_pkg::t_axis_res i_ax_z,
    input  logic [10:0]        i_nx,
    input  logic [20:0]        i_nxny,
    output cpb_pkg::t_cand     o_cand
);

    // stage 7: per axis terms of x + nx*y + nx*ny*z, modulo 2^30
    logic [1:0][29:0] r7_px;
    logic [1:0][29:0] r7_py;
    logic [1:0][29:0] r7_pz;
    logic [2:0]       r7_mark;
    logic [1:0]       r7_yoor;
    logic [1:0]       r7_zoor;
    logic [1:0][29:0] n7_px;
    logic [1:0][29:0] n7_py;
    logic [1:0][29:0] n7_pz;

    always_comb begin
        logic [29:0] nx30;
        logic [29:0] nxny30;
        logic [29:0] yh;
        logic [29:0] yn;
        logic [29:0] zh;
        logic [29:0] zn;
        nx30   = {19'd0, i_nx};
        nxny30 = {9'd0, i_nxny};
        yh     = 30'(i_ax_y.home);
        yn     = 30'(i_ax_y.near);
        zh     = 30'(i_ax_z.home);
        zn     = 30'(i_ax_z.near);
        n7_px[0] = 30'(i_ax_x.home);
        n7_px[1] = 30'(i_ax_x.near);
        n7_py[0] = nx30 * yh;
        n7_py[1] = nx30 * yn;
        n7_pz[0] = nxny30 * zh;
        n7_pz[1] = nxny30 * zn;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_px   <= n7_px;
            r7_py   <= n7_py;
            r7_pz   <= n7_pz;
            r7_mark <= {i_ax_z.marked, i_ax_y.marked, i_ax_x.marked};
            r7_yoor <= {i_ax_y.near_oor, i_ax_y.home_oor};
            r7_zoor <= {i_ax_z.near_oor, i_ax_z.home_oor};
        end
    end

    // stage 8: candidate sums, error flags and which candidates exist
    cpb_pkg::t_cand r8_cand;
    cpb_pkg::t_cand n8_cand;

    always_comb begin
        logic [2:0] m3;
        for (int m = 0; m < 8; m++) begin
            m3 = 3'(m);
            n8_cand.flat[m]  = r7_px[m3[0]] + r7_py[m3[1]] + r7_pz[m3[2]];
            n8_cand.err[m]   = r7_yoor[m3[1]] | r7_zoor[m3[2]];
            n8_cand.use_m[m] = ((m3 & ~r7_mark) == 3'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r8_cand <= n8_cand;
        end
    end

    assign o_cand = r8_cand;

endmodule

// ===== rtl/core/cpb_expand.sv =====
// result sequencer: holds one particle and sends its cells in order through an output register
`timescale 1ns / 1ps

module cpb_expand (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [23:0]    i_id,
    input  cpb_pkg::t_cand i_cand,
    output logic           o_take,
    output logic           o_valid,
    input  logic           i_ready,
    output cpb_pkg::t_out  o_data
);

    logic           r_busy;
    logic [7:0]     r_pend;
    logic [23:0]    r_id;
    cpb_pkg::t_cand r_cand;
    logic           r_ovld;
    cpb_pkg::t_out  r_out;

    logic       out_free;
    logic       fire;
    logic       last;
    logic [2:0] sel;
    logic [7:0] sel_hot;

    // lowest pending candidate goes next
    always_comb begin
        sel = 3'd0;
        for (int m = 7; m >= 0; m--) begin
            if (r_pend[m]) begin
                sel = 3'(m);
            end
        end
        sel_hot = 8'd1 << sel;
    end

    assign out_free = !r_ovld || i_ready;
    assign fire     = r_busy && out_free;
    assign last     = ((r_pend & ~sel_hot) == 8'd0);
    assign o_take   = !r_busy || (fire && last);

    // particle holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pend <= 8'd0;
        end else if (o_take) begin
            r_busy <= i_valid;
            r_pend <= i_valid ? i_cand.use_m : 8'd0;
        end else if (fire) begin
            r_pend <= r_pend & ~sel_hot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_valid) begin
            r_id   <= i_id;
            r_cand <= i_cand;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (fire) begin
            r_ovld <= 1'b1;
        end else if (i_ready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out.particle_id_out  <= r_id;
            r_out.cell_index       <= r_cand.flat[sel];
            r_out.is_neighbour     <= (sel != 3'd0);
            r_out.range_error      <= r_cand.err[sel];
            r_out.last_of_particle <= last;
        end
    end

    assign o_valid = r_ovld;
    assign o_data  = r_out;

endmodule

// ===== rtl/core/particle_cell_binning_core.sv =====
// top level of the particle cell binning core: registers, pipeline and result sequencer
//
//  channel   direction  handshake                   payload
//  input     in         i_in_valid / o_in_ready     i_in_data   (cpb_pkg::t_in)
//  output    out        o_out_valid / i_out_ready   o_out_data  (cpb_pkg::t_out)
//  config    in         i_cfg_we (no wait)          i_cfg_idx, i_cfg_data
//
//  a particle yields one to eight result items; the result sequencer sends one cell per
//  cycle while the output is not stalled, and sets the rate.
//  an eight stage pipeline (six per axis, two for the flat index) takes a new item each
//  cycle unless stalled; its last stage feeds the sequencer's holding and output registers.
//  reset is synchronous; it clears the valid bits and loads the register defaults.
//  a stall on the output holds the pipeline once its last stage is full; nothing is
//  lost or repeated.
`timescale 1ns / 1ps

module particle_cell_binning_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  cpb_pkg::t_in                  i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output cpb_pkg::t_out                 o_out_data,
    input  logic                          i_cfg_we,
    input  logic [cpb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                   i_cfg_data
);

    // configuration registers
    logic [10:0] r_cells_x;
    logic [10:0] r_cells_yz;
    logic [30:0] r_cell_size_x;
    logic [30:0] r_cell_size_yz;
    logic [31:0] r_inv_cell_x;
    logic [31:0] r_inv_cell_yz;
    logic [30:0] r_link_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells_x      <= 11'd64;
            r_cells_yz     <= 11'd64;
            r_cell_size_x  <= 31'd65536;
            r_cell_size_yz <= 31'd65536;
            r_inv_cell_x   <= 32'd16777216;
            r_inv_cell_yz  <= 32'd16777216;
            r_link_dist    <= 31'd13107;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cpb_pkg::CFG_CELLS_X:      r_cells_x      <= i_cfg_data[10:0];
                cpb_pkg::CFG_CELLS_YZ:     r_cells_yz     <= i_cfg_data[10:0];
                cpb_pkg::CFG_CELL_SIZE_X:  r_cell_size_x  <= i_cfg_data[30:0];
                cpb_pkg::CFG_CELL_SIZE_YZ: r_cell_size_yz <= i_cfg_data[30:0];
                cpb_pkg::CFG_INV_CELL_X:   r_inv_cell_x   <= i_cfg_data;
                cpb_pkg::CFG_INV_CELL_YZ:  r_inv_cell_yz  <= i_cfg_data;
                cpb_pkg::CFG_LINK_DIST:    r_link_dist    <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // effective cell counts and the z stride
    logic [10:0] nx;
    logic [10:0] ny;
    logic [21:0] nxny_full;
    logic [20:0] r_nxny;
    assign nx        = cpb_pkg::eff_count(r_cells_x);
    assign ny        = cpb_pkg::eff_count(r_cells_yz);
    assign nxny_full = nx * ny;

    always_ff @(posedge i_clk) begin
        r_nxny <= nxny_full[20:0];
    end

    // pipeline advance: the last stage is empty or the sequencer takes it
    logic       en;
    logic       take;
    logic [7:0] r_vld;
    logic [23:0] r_id [8];

    assign en         = !r_vld[7] || take;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 8'd0;
        end else if (en) begin
            r_vld <= {r_vld[6:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_id[0] <= i_in_data.particle_id;
            for (int k = 1; k < 8; k++) begin
                r_id[k] <= r_id[k-1];
            end
        end
    end

    // per axis binning
    cpb_pkg::t_axis_res ax_x;
    cpb_pkg::t_axis_res ax_y;
    cpb_pkg::t_axis_res ax_z;

    cpb_axis u_axis_x (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_clamp (1'b1),
        .i_pos   (i_in_data.pos_x),
        .i_inv   (r_inv_cell_x),
        .i_size  (r_cell_size_x),
        .i_link  (r_link_dist),
        .i_n     (nx),
        .o_res   (ax_x)
    );

    cpb_axis u_axis_y (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_clamp (1'b0),
        .i_pos   (i_in_data.pos_y),
        .i_inv   (r_inv_cell_yz),
        .i_size  (r_cell_size_yz),
        .i_link  (r_link_dist),
        .i_n     (ny),
        .o_res   (ax_y)
    );

    cpb_axis u_axis_z (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_clamp (1'b0),
        .i_pos   (i_in_data.pos_z),
        .i_inv   (r_inv_cell_yz),
        .i_size  (r_cell_size_yz),
        .i_link  (r_link_dist),
        .i_n     (ny),
        .o_res   (ax_z)
    );

    // flat index of every candidate cell
    cpb_pkg::t_cand cand;

    cpb_flat u_flat (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_ax_x (ax_x),
        .i_ax_y (ax_y),
        .i_ax_z (ax_z),
        .i_nx   (nx),
        .i_nxny (r_nxny),
        .o_cand (cand)
    );

    // result sequencer
    cpb_expand u_expand (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld[7]),
        .i_id    (r_id[7]),
        .i_cand  (cand),
        .o_take  (take),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

// ===== rtl/core/cpb_checker.sv =====
// port level checks for the particle cell binning core, bound to the top level
`timescale 1ns / 1ps

module cpb_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input cpb_pkg::t_out o_out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result item changed or dropped");

    // leaving reset: nothing to send, ready for an item
    a_reset_state: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_out_valid && o_in_ready)
        else $error("bad state after reset");

    // the cells of one particle follow each other without a gap
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_data.last_of_particle |=> o_out_valid)
        else $error("gap inside the results of one particle");

    // every cell after the first of a particle is a neighbour of the same particle
    a_same_particle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_data.last_of_particle |=>
            o_out_data.is_neighbour &&
            (o_out_data.particle_id_out == $past(o_out_data.particle_id_out)))
        else $error("particle changed before its last result item");

endmodule

bind particle_cell_binning_core cpb_checker u_cpb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== bench/tb_top.sv =====
// self-checking bench for the particle cell binning core, with its own binning predictor
`timescale 1ns / 1ps

module tb_top;

    localparam int ONE_Q16 = 65536;
    localparam int SETTLE_CYCLES = 32;
    localparam int TIMEOUT_NS = 4000000;
    localparam longint SPAN_CAP = 1073741824;
    localparam logic [cpb_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    // register file as the block holds it
    typedef struct packed {
        logic [10:0] cells_x;
        logic [10:0] cells_yz;
        logic [30:0] size_x;
        logic [30:0] size_yz;
        logic [31:0] inv_x;
        logic [31:0] inv_yz;
        logic [30:0] link;
    } bin_cfg_t;

    localparam bin_cfg_t CFG_AT_RESET = '{
        cells_x: 11'd64, cells_yz: 11'd64, size_x: 31'd65536, size_yz: 31'd65536,
        inv_x: 32'd16777216, inv_yz: 32'd16777216, link: 31'd13107
    };

    // binning of one axis
    typedef struct {
        longint home;
        longint near;
        bit     marked;
    } axis_bin_t;

    // work for the driver: an item, a register write, or a wait for the block to go idle
    typedef enum logic [1:0] {OP_ITEM, OP_CFG, OP_DRAIN} op_kind_t;

    typedef struct {
        op_kind_t                      kind;
        cpb_pkg::t_in                  item;
        logic [cpb_pkg::CFG_IDX_W-1:0] idx;
        logic [31:0]                   data;
    } bench_op_t;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    cpb_pkg::t_in                  i_in_data = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    cpb_pkg::t_out                 o_out_data;
    logic                          i_cfg_we = 1'b0;
    logic [cpb_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [31:0]                   i_cfg_data = '0;

    bench_op_t     pending_ops[$];
    cpb_pkg::t_out expected_cells[$];
    bin_cfg_t      gen_cfg = CFG_AT_RESET;
    bin_cfg_t      model_cfg = CFG_AT_RESET;

    int  cycle_cnt = 0;
    int  err_count = 0;
    int  n_items = 0;
    int  n_results = 0;
    int  n_nbr = 0;
    int  n_rerr = 0;
    int  n_cfg = 0;
    int  tx_gap = 0;
    int  rx_stall = 0;
    int  drain_cnt = 0;
    bit  drv_valid;
    bit  drv_we;
    bit  tx_quiet;
    bit  rx_quiet;
    bench_op_t     op;
    cpb_pkg::t_out want;

    particle_cell_binning_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // free-running cycle count, sets the stretches with no idling
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    assign tx_quiet = (cycle_cnt % 1000) < 150;
    assign rx_quiet = ((cycle_cnt + 500) % 1000) < 150;

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // register write with the field widths applied, unknown index ignored
    function automatic bin_cfg_t cfg_written(input bin_cfg_t c,
                                             input logic [cpb_pkg::CFG_IDX_W-1:0] idx,
                                             input logic [31:0] d);
        bin_cfg_t r;
        r = c;
        case (idx)
            cpb_pkg::CFG_CELLS_X:      r.cells_x = d[10:0];
            cpb_pkg::CFG_CELLS_YZ:     r.cells_yz = d[10:0];
            cpb_pkg::CFG_CELL_SIZE_X:  r.size_x = d[30:0];
            cpb_pkg::CFG_CELL_SIZE_YZ: r.size_yz = d[30:0];
            cpb_pkg::CFG_INV_CELL_X:   r.inv_x = d;
            cpb_pkg::CFG_INV_CELL_YZ:  r.inv_yz = d;
            cpb_pkg::CFG_LINK_DIST:    r.link = d[30:0];
            default: ;
        endcase
        return r;
    endfunction

    // cell count in use: zero acts as one, above the limit acts as the limit
    function automatic longint eff_cells(input logic [10:0] n);
        if (n == 11'd0) return 1;
        if (n > 11'd1024) return 1024;
        return longint'(n);
    endfunction

    // home index, nearest edge and neighbour across it on one axis
    function automatic axis_bin_t bin_one_axis(input logic signed [31:0] pos,
                                               input logic [31:0] inv,
                                               input logic [30:0] size,
                                               input logic [30:0] lk,
                                               input longint n,
                                               input bit clamp);
        axis_bin_t   r;
        longint      p, sz, trunc, rnd, ic, diff, c;
        logic [63:0] mag, prod;
        bit          neg;
        p = pos;
        sz = size;
        neg = (p < 0);
        mag = neg ? -p : p;
        prod = mag * {32'd0, inv};
        trunc = longint'(prod >> 40);
        if (neg) trunc = -trunc;
        // nearest edge, a negative product at or below one half goes to edge zero
        if (!neg) rnd = longint'((prod + cpb_pkg::HALF_Q40) >> 40);
        else if (prod <= cpb_pkg::HALF_Q40) rnd = 0;
        else rnd = -longint'((prod - cpb_pkg::HALF_Q40) >> 40);
        diff = rnd * sz - p;
        if (diff < 0) diff = -diff;
        // x clamps, y and z wrap once
        if (trunc >= n) ic = clamp ? n - 1 : trunc - n;
        else if (trunc < 0) ic = clamp ? 0 : trunc + n;
        else ic = trunc;
        r.home = ic;
        r.near = 0;
        r.marked = 1'b0;
        if (diff <= longint'(lk)) begin
            c = ic - 1 + 2 * (rnd - trunc);
            r.marked = 1'b1;
            if (c >= n) begin
                if (clamp) r.marked = 1'b0;
                else c = c - n;
            end else if (c < 0) begin
                if (clamp) r.marked = 1'b0;
                else c = c + n;
            end
            r.near = r.marked ? c : 0;
        end
        return r;
    endfunction

    // expected cell items of one particle: home first, then marked-axis subsets in order
    task automatic predict_cells(input cpb_pkg::t_in it);
        axis_bin_t     ax [3];
        cpb_pkg::t_out res [8];
        longint        nx, ny, xs, ys, zs, flat;
        logic [2:0]    marked, sel;
        int            cnt;
        nx = eff_cells(model_cfg.cells_x);
        ny = eff_cells(model_cfg.cells_yz);
        ax[0] = bin_one_axis(it.pos_x, model_cfg.inv_x, model_cfg.size_x, model_cfg.link,
                             nx, 1'b1);
        ax[1] = bin_one_axis(it.pos_y, model_cfg.inv_yz, model_cfg.size_yz, model_cfg.link,
                             ny, 1'b0);
        ax[2] = bin_one_axis(it.pos_z, model_cfg.inv_yz, model_cfg.size_yz, model_cfg.link,
                             ny, 1'b0);
        marked = {ax[2].marked, ax[1].marked, ax[0].marked};
        cnt = 0;
        for (int m = 0; m < 8; m++) begin
            sel = 3'(m);
            if ((sel & ~marked) == 3'b000) begin
                xs = sel[0] ? ax[0].near : ax[0].home;
                ys = sel[1] ? ax[1].near : ax[1].home;
                zs = sel[2] ? ax[2].near : ax[2].home;
                flat = xs + nx * (ys + ny * zs);
                res[cnt].particle_id_out = it.particle_id;
                res[cnt].cell_index = flat[29:0];
                res[cnt].is_neighbour = (sel != 3'b000);
                res[cnt].range_error = (ys < 0 || ys >= ny || zs < 0 || zs >= ny);
                res[cnt].last_of_particle = 1'b0;
                cnt++;
            end
        end
        res[cnt-1].last_of_particle = 1'b1;
        for (int k = 0; k < cnt; k++) expected_cells.push_back(res[k]);
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, exp_val));
    endtask

    // stimulus queue fillers
    task automatic push_item(input logic [23:0] id, input logic [31:0] x,
                             input logic [31:0] y, input logic [31:0] z);
        bench_op_t o;
        o.kind = OP_ITEM;
        o.item.particle_id = id;
        o.item.pos_x = x;
        o.item.pos_y = y;
        o.item.pos_z = z;
        o.idx = '0;
        o.data = '0;
        pending_ops.push_back(o);
    endtask

    task automatic push_cfg(input logic [cpb_pkg::CFG_IDX_W-1:0] idx,
                            input logic [31:0] data);
        bench_op_t o;
        o.kind = OP_CFG;
        o.item = '0;
        o.idx = idx;
        o.data = data;
        pending_ops.push_back(o);
        gen_cfg = cfg_written(gen_cfg, idx, data);
    endtask

    task automatic push_drain();
        bench_op_t o;
        o.kind = OP_DRAIN;
        o.item = '0;
        o.idx = '0;
        o.data = '0;
        pending_ops.push_back(o);
    endtask

    function automatic logic [10:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return 11'd0;
        if (r < 10) return 11'($urandom_range(1025, 2047));
        if (r < 60) return 11'($urandom_range(1, 16));
        if (r < 85) return 11'($urandom_range(17, 128));
        return 11'($urandom_range(129, 1024));
    endfunction

    function automatic logic [30:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 31'($urandom_range(32'h1000, 32'h80000));
        if (r < 90) return 31'($urandom_range(1, 32'h1000));
        return 31'($urandom_range(32'h80000, 32'h7FFFFFFF));
    endfunction

    // q8.24 reciprocal of a q16.16 size, saturated, sometimes a little off
    function automatic logic [31:0] recip_q824(input logic [30:0] s);
        logic [63:0] q;
        if (s == 31'd0) q = 64'hFFFFFFFF;
        else q = (64'd1 << 40) / s;
        if (q > 64'hFFFFFFFF) q = 64'hFFFFFFFF;
        if ($urandom_range(0, 3) == 0) q[7:0] = 8'($urandom);
        return q[31:0];
    endfunction

    // position on one axis: mostly close to a cell edge in or next to the grid
    function automatic logic [31:0] axis_pos(input longint n, input logic [30:0] size,
                                             input logic [30:0] lk);
        longint k, sz, span, p;
        int     r;
        sz = size;
        span = 2 * longint'(lk) + 2;
        if (span > SPAN_CAP) span = SPAN_CAP;
        r = $urandom_range(0, 99);
        k = longint'($urandom_range(0, 32'(n + 3))) - 2;
        if (r >= 10 && r < 16) k = longint'($urandom_range(0, 32'(6 * n))) - 3 * n;
        if (r < 10) p = longint'($urandom);
        else if (r < 70) p = k * sz + longint'($urandom_range(0, 32'(span))) - span / 2;
        else p = k * sz + longint'($urandom_range(0, 32'(sz)));
        return p[31:0];
    endfunction

    task automatic random_items(input int count);
        longint nx, ny;
        nx = eff_cells(gen_cfg.cells_x);
        ny = eff_cells(gen_cfg.cells_yz);
        for (int i = 0; i < count; i++)
            push_item(24'($urandom), axis_pos(nx, gen_cfg.size_x, gen_cfg.link),
                      axis_pos(ny, gen_cfg.size_yz, gen_cfg.link),
                      axis_pos(ny, gen_cfg.size_yz, gen_cfg.link));
    endtask

    // driver: items, register writes and idle waits from the pending queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_cfg_we <= 1'b0;
            model_cfg = CFG_AT_RESET;
            tx_gap = 0;
            drain_cnt = 0;
        end else begin
            drv_valid = i_in_valid;
            drv_we = 1'b0;
            if (i_in_valid && o_in_ready) begin
                predict_cells(i_in_data);
                n_items++;
                drv_valid = 1'b0;
            end
            if (!drv_valid) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (pending_ops.size() != 0) begin
                    op = pending_ops[0];
                    case (op.kind)
                        OP_ITEM: begin
                            i_in_data <= op.item;
                            drv_valid = 1'b1;
                            pending_ops.delete(0);
                            tx_gap = pick_gap(tx_quiet);
                        end
                        OP_CFG: begin
                            i_cfg_idx <= op.idx;
                            i_cfg_data <= op.data;
                            drv_we = 1'b1;
                            model_cfg = cfg_written(model_cfg, op.idx, op.data);
                            n_cfg++;
                            pending_ops.delete(0);
                            tx_gap = 2;
                        end
                        OP_DRAIN: begin
                            // hold off until nothing is owed, then let the pipeline settle
                            if (expected_cells.size() != 0) begin
                                drain_cnt = 0;
                            end else if (drain_cnt < SETTLE_CYCLES) begin
                                drain_cnt++;
                            end else begin
                                drain_cnt = 0;
                                pending_ops.delete(0);
                            end
                        end
                        default: pending_ops.delete(0);
                    endcase
                end
            end
            i_in_valid <= drv_valid;
            i_cfg_we <= drv_we;
        end
    end

    // monitor: random back-pressure and in-order compare of result items
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                n_results++;
                if (expected_cells.size() == 0) begin
                    report_mismatch($sformatf("item for particle 0x%0h with nothing expected",
                                              o_out_data.particle_id_out));
                end else begin
                    want = expected_cells.pop_front();
                    check_field("particle_id_out", 32'(o_out_data.particle_id_out),
                                32'(want.particle_id_out));
                    check_field("cell_index", 32'(o_out_data.cell_index),
                                32'(want.cell_index));
                    check_field("is_neighbour", 32'(o_out_data.is_neighbour),
                                32'(want.is_neighbour));
                    check_field("range_error", 32'(o_out_data.range_error),
                                32'(want.range_error));
                    check_field("last_of_particle", 32'(o_out_data.last_of_particle),
                                32'(want.last_of_particle));
                    if (want.is_neighbour) n_nbr++;
                    if (want.range_error) n_rerr++;
                end
            end
            if (rx_stall > 0) begin
                rx_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                rx_stall = pick_gap(rx_quiet);
            end
        end
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d items still expected", expected_cells.size());
        $display("** particle_cell_binning_core: FAILED **");
        $finish;
    end

    // stimulus plan, reset and end of run
    initial begin
        int ph, r;
        logic [30:0] sx, syz, lk;

        // reset defaults: 64 cells, unit cells, link of 0.2
        push_item(24'h000000, 0, 0, 0);
        push_item(24'hFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        push_item(24'h000001, 32'h80000000, 32'h80000000, 32'h80000000);
        // exactly half a cell, both signs
        push_item(24'h000002, 32768, 32768, 32768);
        push_item(24'h000003, -32768, -32768, -32768);
        // all three axes near an edge, eight cells
        push_item(24'h000004, 10 * ONE_Q16 + 6554, 20 * ONE_Q16 + 6554, 30 * ONE_Q16 + 62259);
        // near the top edge: x neighbour dropped, y and z wrap to zero
        push_item(24'h000005, 63 * ONE_Q16 + 58982, 63 * ONE_Q16 + 58982, 63 * ONE_Q16 + 58982);
        // just below zero
        push_item(24'h000006, -6554, -6554, -6554);
        // edge distance equal to the link distance, then one step beyond
        push_item(24'h000007, ONE_Q16 - 13107, ONE_Q16 - 13107, ONE_Q16 - 13107);
        push_item(24'h000008, ONE_Q16 - 13108, ONE_Q16 - 13108, ONE_Q16 - 13108);
        // far outside on y and z, still out after the wrap
        push_item(24'h000009, 5 * ONE_Q16, 200 * ONE_Q16 + 3277, -(200 * ONE_Q16 + 3277));
        // x beyond the grid on both sides
        push_item(24'h00000A, 100 * ONE_Q16, -70 * ONE_Q16, 130 * ONE_Q16);
        push_item(24'h00000B, -3 * ONE_Q16 - 6554, 32 * ONE_Q16 + 100, 5 * ONE_Q16);
        random_items(60);

        // zero counts, widest link
        push_drain();
        push_cfg(cpb_pkg::CFG_CELLS_X, 32'hFFFFF800);
        push_cfg(cpb_pkg::CFG_CELLS_YZ, 32'h00000000);
        push_cfg(cpb_pkg::CFG_CELL_SIZE_X, 32'd65536);
        push_cfg(cpb_pkg::CFG_CELL_SIZE_YZ, 32'd65536);
        push_cfg(cpb_pkg::CFG_INV_CELL_X, 32'd16777216);
        push_cfg(cpb_pkg::CFG_INV_CELL_YZ, 32'd16777216);
        push_cfg(cpb_pkg::CFG_LINK_DIST, 32'hFFFFFFFF);
        push_item(24'h000010, 0, 0, 0);
        push_item(24'h000011, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        push_item(24'h000012, 32'h80000000, 32'h80000000, 32'h80000000);
        random_items(30);

        // counts at and above the limit, largest size and reciprocal, no link
        push_drain();
        push_cfg(cpb_pkg::CFG_CELLS_X, 32'hFFFFFFFF);
        push_cfg(cpb_pkg::CFG_CELLS_YZ, 32'd1024);
        push_cfg(cpb_pkg::CFG_CELL_SIZE_X, 32'hFFFFFFFF);
        push_cfg(cpb_pkg::CFG_CELL_SIZE_YZ, 32'h7FFFFFFF);
        push_cfg(cpb_pkg::CFG_INV_CELL_X, 32'hFFFFFFFF);
        push_cfg(cpb_pkg::CFG_INV_CELL_YZ, 32'hFFFFFFFF);
        push_cfg(cpb_pkg::CFG_LINK_DIST, 32'h00000000);
        push_cfg(CFG_UNUSED_IDX, $urandom);
        push_item(24'h000020, 0, 0, 0);
        push_item(24'h000021, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        push_item(24'h000022, 32'h80000000, 32'h80000000, 32'h80000000);
        random_items(30);

        // zero sizes and reciprocals, single x cell, y and z over the limit
        push_drain();
        push_cfg(cpb_pkg::CFG_CELLS_X, 32'd1);
        push_cfg(cpb_pkg::CFG_CELLS_YZ, 32'd1025);
        push_cfg(cpb_pkg::CFG_CELL_SIZE_X, 32'd0);
        push_cfg(cpb_pkg::CFG_CELL_SIZE_YZ, 32'd0);
        push_cfg(cpb_pkg::CFG_INV_CELL_X, 32'd0);
        push_cfg(cpb_pkg::CFG_INV_CELL_YZ, 32'd0);
        push_cfg(cpb_pkg::CFG_LINK_DIST, $urandom_range(0, 4000));
        random_items(20);

        // random grids, pausing for the pipeline to empty half way through each
        for (ph = 0; ph < 6; ph++) begin
            push_drain();
            sx = pick_size();
            syz = pick_size();
            r = $urandom_range(0, 99);
            if (r < 15) lk = 31'd0;
            else if (r < 85) lk = 31'($urandom_range(0, 32'(syz / 2)));
            else lk = 31'($urandom_range(0, 32'h7FFFFFFF));
            push_cfg(cpb_pkg::CFG_CELLS_X, {21'($urandom), pick_count()});
            push_cfg(cpb_pkg::CFG_CELLS_YZ, {21'($urandom), pick_count()});
            push_cfg(cpb_pkg::CFG_CELL_SIZE_X, {1'($urandom), sx});
            push_cfg(cpb_pkg::CFG_CELL_SIZE_YZ, {1'($urandom), syz});
            push_cfg(cpb_pkg::CFG_INV_CELL_X, recip_q824(sx));
            push_cfg(cpb_pkg::CFG_INV_CELL_YZ, recip_q824(syz));
            push_cfg(cpb_pkg::CFG_LINK_DIST, {1'($urandom), lk});
            random_items(25);
            push_drain();
            random_items(25);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_ops.size() != 0 || i_in_valid) @(posedge i_clk);
        while (expected_cells.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d particles over %0d register writes and 10 grid settings",
                 n_items, n_cfg);
        $display("checked %0d cell items: %0d neighbour cells, %0d flagged outside the grid",
                 n_results, n_nbr, n_rerr);
        if (err_count == 0) begin
            $display("** particle_cell_binning_core: PASSED **");
        end else begin
            $display("%0d mismatches", err_count);
            $display("** particle_cell_binning_core: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/cpb_pkg.sv
rtl/core/cpb_axis.sv
rtl/core/cpb_flat.sv
rtl/core/cpb_expand.sv
rtl/core/particle_cell_binning_core.sv
rtl/core/cpb_checker.sv
bench/tb_top.sv
